FILE: src/wss_pkg.sv
`timescale 1ns / 1ps

package wss_pkg;

    // Pattern capacity and the widths that follow from it.
    localparam int MaxTokens = 32;
    localparam int CountW    = $clog2(MaxTokens + 1);
    localparam int PosW      = MaxTokens + 1;

    // Pattern characters with a special meaning.
    localparam logic [7:0] ChEsc   = 8'h5C;
    localparam logic [7:0] ChStar  = 8'h2A;
    localparam logic [7:0] ChQuest = 8'h3F;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_END    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_LIT = 2'd0,
        KIND_ONE = 2'd1,
        KIND_RUN = 2'd2
    } t_kind;

    // Decoded pattern as the matcher sees it. The kind flags at or above count are all zero.
    typedef struct packed {
        logic [MaxTokens-1:0]      run;
        logic [MaxTokens-1:0]      one;
        logic [MaxTokens-1:0]      lit;
        logic [MaxTokens-1:0][7:0] lit_byte;
        logic [CountW-1:0]         count;
    } t_pattern;

    typedef struct packed {
        logic found;
        logic text_done;
        logic pattern_full;
    } t_result;

endpackage

FILE: src/wss_tokens.sv
`timescale 1ns / 1ps

module wss_tokens (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  wss_pkg::t_cmd       i_cmd,
    input  logic [7:0]          i_data,
    output wss_pkg::t_pattern   o_view,
    output logic                o_overflow
);

    wss_pkg::t_kind                 r_kind [wss_pkg::MaxTokens];
    logic [7:0]                     r_byte [wss_pkg::MaxTokens];
    logic [wss_pkg::CountW-1:0]     r_count;
    logic                           r_escape;
    logic                           r_overflow;

    wss_pkg::t_kind                 n_kind [wss_pkg::MaxTokens];
    logic [7:0]                     n_byte [wss_pkg::MaxTokens];
    logic [wss_pkg::CountW-1:0]     n_count;
    logic                           n_escape;
    logic                           n_overflow;

    logic                           w_clear;
    logic                           w_a_valid;
    wss_pkg::t_kind                 w_a_kind;
    logic [7:0]                     w_a_byte;
    logic                           w_b_valid;
    wss_pkg::t_kind                 w_b_kind;
    logic [7:0]                     w_b_byte;
    logic                           w_a_ok;
    logic                           w_b_ok;
    logic [wss_pkg::CountW-1:0]     w_cnt1;
    logic                           w_is_esc;
    logic                           w_is_star;
    logic                           w_is_quest;

    assign w_is_esc   = (i_data == wss_pkg::ChEsc);
    assign w_is_star  = (i_data == wss_pkg::ChStar);
    assign w_is_quest = (i_data == wss_pkg::ChQuest);

    // Parse one command into at most two tokens to append.
    always_comb begin
        w_clear   = 1'b0;
        w_a_valid = 1'b0;
        w_a_kind  = wss_pkg::KIND_LIT;
        w_a_byte  = i_data;
        w_b_valid = 1'b0;
        w_b_kind  = wss_pkg::KIND_LIT;
        w_b_byte  = i_data;
        n_escape  = r_escape;
        if (i_accept) begin
            unique case (i_cmd)
                wss_pkg::CMD_START: begin
                    w_clear  = 1'b1;
                    n_escape = 1'b0;
                end
                wss_pkg::CMD_APPEND: begin
                    if (r_escape) begin
                        n_escape  = 1'b0;
                        w_a_valid = 1'b1;
                        if (!(w_is_star || w_is_quest)) begin
                            // The backslash was literal; the new character is parsed afresh.
                            w_a_byte = wss_pkg::ChEsc;
                            if (w_is_esc) begin
                                n_escape = 1'b1;
                            end else begin
                                w_b_valid = 1'b1;
                            end
                        end
                    end else if (w_is_esc) begin
                        n_escape = 1'b1;
                    end else begin
                        w_a_valid = 1'b1;
                        if (w_is_star) begin
                            w_a_kind = wss_pkg::KIND_RUN;
                        end else if (w_is_quest) begin
                            w_a_kind = wss_pkg::KIND_ONE;
                        end
                    end
                end
                wss_pkg::CMD_TEXT, wss_pkg::CMD_END: begin
                    // A trailing backslash becomes a literal before the text is matched.
                    if (r_escape) begin
                        n_escape  = 1'b0;
                        w_a_valid = 1'b1;
                        w_a_byte  = wss_pkg::ChEsc;
                    end
                end
            endcase
        end
    end

    // Place the tokens while capacity remains; record any that are dropped.
    always_comb begin
        w_a_ok     = w_a_valid && (r_count < wss_pkg::CountW'(wss_pkg::MaxTokens));
        w_cnt1     = r_count + wss_pkg::CountW'(w_a_ok);
        w_b_ok     = w_b_valid && (w_cnt1 < wss_pkg::CountW'(wss_pkg::MaxTokens));
        n_count    = w_clear ? '0 : w_cnt1 + wss_pkg::CountW'(w_b_ok);
        n_overflow = w_clear ? 1'b0 :
                     (r_overflow | (w_a_valid & ~w_a_ok) | (w_b_valid & ~w_b_ok));
        for (int i = 0; i < wss_pkg::MaxTokens; i++) begin
            n_kind[i] = r_kind[i];
            n_byte[i] = r_byte[i];
            if (w_a_ok && (r_count == wss_pkg::CountW'(i))) begin
                n_kind[i] = w_a_kind;
                n_byte[i] = w_a_byte;
            end
            if (w_b_ok && (w_cnt1 == wss_pkg::CountW'(i))) begin
                n_kind[i] = w_b_kind;
                n_byte[i] = w_b_byte;
            end
        end
    end

    // Decoded view of the pattern as it stands after this command.
    always_comb begin
        for (int i = 0; i < wss_pkg::MaxTokens; i++) begin
            o_view.run[i]      = (wss_pkg::CountW'(i) < n_count) && (n_kind[i] == wss_pkg::KIND_RUN);
            o_view.one[i]      = (wss_pkg::CountW'(i) < n_count) && (n_kind[i] == wss_pkg::KIND_ONE);
            o_view.lit[i]      = (wss_pkg::CountW'(i) < n_count) && (n_kind[i] == wss_pkg::KIND_LIT);
            o_view.lit_byte[i] = n_byte[i];
        end
        o_view.count = n_count;
    end

    assign o_overflow = n_overflow;

    // Token storage holds no reset: entries at or above the count are never used.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < wss_pkg::MaxTokens; i++) begin
            r_kind[i] <= n_kind[i];
            r_byte[i] <= n_byte[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_escape   <= 1'b0;
            r_overflow <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_escape   <= n_escape;
            r_overflow <= n_overflow;
        end
    end

endmodule

FILE: src/wss_match.sv
`timescale 1ns / 1ps

module wss_match (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  wss_pkg::t_cmd       i_cmd,
    input  logic [7:0]          i_data,
    input  wss_pkg::t_pattern   i_view,
    input  logic                i_overflow,
    output wss_pkg::t_result    o_result
);

    logic [wss_pkg::PosW-1:0]       r_active;
    logic                           r_match;
    logic [wss_pkg::PosW-1:0]       n_active;
    logic                           n_match;

    logic [wss_pkg::PosW-1:0]       w_start_set;
    logic [wss_pkg::PosW-1:0]       w_text_set;
    logic [wss_pkg::PosW-1:0]       w_stepped;
    logic [wss_pkg::MaxTokens-1:0]  w_adv;
    logic [wss_pkg::MaxTokens-1:0]  w_keep;
    logic                           w_end_hit;

    // Closure over star tokens: a set position i with a star at i also sets i+1,
    // and so on along a run of stars. This is a carry chain, so one add does it.
    function automatic logic [wss_pkg::PosW-1:0] close_runs(
        input logic [wss_pkg::PosW-1:0]      s,
        input logic [wss_pkg::MaxTokens-1:0] run
    );
        logic [wss_pkg::PosW-1:0] r;
        logic [wss_pkg::PosW-1:0] g;
        logic [wss_pkg::PosW:0]   sum;
        r   = {1'b0, run};
        g   = s & r;
        sum = {1'b0, r} + {1'b0, g};
        close_runs = s | (sum[wss_pkg::PosW-1:0] ^ r ^ g);
    endfunction

    // Advance every active position by one text byte.
    always_comb begin
        for (int i = 0; i < wss_pkg::MaxTokens; i++) begin
            w_adv[i]  = r_active[i] & (i_view.one[i] |
                        (i_view.lit[i] & (i_view.lit_byte[i] == i_data)));
            w_keep[i] = r_active[i] & i_view.run[i];
        end
        w_stepped   = {w_adv, 1'b0} | {1'b0, w_keep} | wss_pkg::PosW'(1);
        w_text_set  = close_runs(w_stepped, i_view.run);
        w_start_set = close_runs(wss_pkg::PosW'(1), i_view.run);
        // Any token added by a flushed backslash is literal, so the set needs no re-closure.
        w_end_hit   = r_active[i_view.count];
    end

    // Next text state and the result of the transfer.
    always_comb begin
        n_active              = r_active;
        n_match               = r_match;
        o_result.found        = 1'b0;
        o_result.text_done    = 1'b0;
        o_result.pattern_full = i_overflow;
        if (i_accept) begin
            unique case (i_cmd)
                wss_pkg::CMD_START, wss_pkg::CMD_APPEND: begin
                    n_active = w_start_set;
                    n_match  = 1'b0;
                end
                wss_pkg::CMD_TEXT: begin
                    n_active       = w_text_set;
                    n_match        = r_match | w_end_hit | w_text_set[i_view.count];
                    o_result.found = n_match;
                end
                wss_pkg::CMD_END: begin
                    n_active           = w_start_set;
                    n_match            = 1'b0;
                    o_result.found     = r_match | w_end_hit;
                    o_result.text_done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= wss_pkg::PosW'(1);
            r_match  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_match  <= n_match;
        end
    end

endmodule

FILE: src/wss_outbuf.sv
`timescale 1ns / 1ps

module wss_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wss_pkg::t_result    i_data,
    output logic                o_full,
    output logic                o_valid,
    output wss_pkg::t_result    o_data,
    input  logic                i_stall
);

    logic               r_main_valid;
    logic               r_skid_valid;
    wss_pkg::t_result   r_main;
    wss_pkg::t_result   r_skid;
    logic               n_main_valid;
    logic               n_skid_valid;
    wss_pkg::t_result   n_main;
    wss_pkg::t_result   n_skid;
    logic               w_take;

    assign w_take = r_main_valid & ~i_stall;

    // Two-entry buffer: the skid entry catches a result while the output is stalled.
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (w_take) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_main = i_data;
            end else begin
                n_main_valid = 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid) begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end else begin
                n_main       = i_data;
                n_main_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

endmodule

FILE: src/wildcard_substring_search.sv
`timescale 1ns / 1ps
// A result is registered into the two-entry output buffer on its input transfer.
// Throughput: one item per cycle while not stalled; the pattern and active-position
// updates are one combinational step between the state registers and that buffer.
// Input stall rises only when both output entries hold results.
// Reset (synchronous, active low) empties the pattern, clears all flags and the buffer.
module wildcard_substring_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_data,
    output logic        o_stall,
    output logic        o_valid,
    output logic        o_found,
    output logic        o_text_done,
    output logic        o_pattern_full,
    input  logic        i_stall
);

    wss_pkg::t_cmd      w_cmd;
    wss_pkg::t_pattern  w_view;
    wss_pkg::t_result   w_result;
    wss_pkg::t_result   w_out;
    logic               w_accept;
    logic               w_overflow;
    logic               w_full;

    assign w_cmd    = wss_pkg::t_cmd'(i_cmd);
    assign w_accept = i_valid & ~w_full;

    // Pattern parsing and token storage.
    wss_tokens u_tokens (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_cmd      (w_cmd),
        .i_data     (i_data),
        .o_view     (w_view),
        .o_overflow (w_overflow)
    );

    // Active-position set and sticky match flag.
    wss_match u_match (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_cmd      (w_cmd),
        .i_data     (i_data),
        .i_view     (w_view),
        .i_overflow (w_overflow),
        .o_result   (w_result)
    );

    // Result buffer between the two channels.
    wss_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_valid),
        .o_data  (w_out),
        .i_stall (i_stall)
    );

    assign o_stall        = w_full;
    assign o_found        = w_out.found;
    assign o_text_done    = w_out.text_done;
    assign o_pattern_full = w_out.pattern_full;

    // Every transfer leaves a result waiting at the output.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_valid)
        else $error("Accepted item produced no result");

    // The skid entry is only used behind a full output register.
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("Skid entry holds a result while the output register is empty");

    // A new pattern clears every flag in its result.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_cmd == wss_pkg::CMD_START)) |->
        (!w_result.found && !w_result.text_done && !w_result.pattern_full))
        else $error("Start command produced a non-zero result");

endmodule
